@@ hdl/srrlc_pkg.sv @@
// ----------------------------------------------------------------------------
// srrlc_pkg
// lighting mode codes and color wheel band table for the sound reactive
// rgb light controller
// ----------------------------------------------------------------------------
package srrlc_pkg;

    // lighting modes
    localparam logic [2:0] MODE_CLAP  = 3'd0;
    localparam logic [2:0] MODE_BLUE  = 3'd1;
    localparam logic [2:0] MODE_GREEN = 3'd2;
    localparam logic [2:0] MODE_RED   = 3'd3;
    localparam logic [2:0] MODE_WHITE = 3'd4;
    localparam logic [2:0] MODE_WHEEL = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_QUIET_CENTER   = 2'd0;
    localparam logic [1:0] CFG_QUIET_DEADBAND = 2'd1;
    localparam logic [1:0] CFG_CLAP_HOLD_MS   = 2'd2;
    localparam logic [1:0] CFG_CLAP_GAP_MS    = 2'd3;

    localparam int NUM_BANDS = 9;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam logic [7:0] LVL_OFF  = 8'd0;
    localparam logic [7:0] LVL_FULL = 8'd255;

    // color of one wheel band, bands past the last saturate
    function automatic t_rgb band_color(input logic [3:0] band);
        t_rgb c;
        case (band)
            4'd0:    c = '{8'd255, 8'd0,   8'd0};
            4'd1:    c = '{8'd170, 8'd85,  8'd0};
            4'd2:    c = '{8'd85,  8'd170, 8'd0};
            4'd3:    c = '{8'd0,   8'd255, 8'd0};
            4'd4:    c = '{8'd0,   8'd170, 8'd85};
            4'd5:    c = '{8'd0,   8'd85,  8'd170};
            4'd6:    c = '{8'd0,   8'd0,   8'd255};
            4'd7:    c = '{8'd85,  8'd0,   8'd170};
            default: c = '{8'd170, 8'd0,   8'd85};
        endcase
        return c;
    endfunction

endpackage

@@ hdl/sound_reactive_rgb_light_controller.sv @@
// ----------------------------------------------------------------------------
// sound_reactive_rgb_light_controller
// turns a microphone sample stream into rgb duty levels in six modes
// ----------------------------------------------------------------------------
// One beat per sample tick carries a microphone sample, the mode button level
// and a millisecond timestamp; one result beat comes back per tick with the
// red, green and blue duty levels, the mode in force and the clap count.
// The block takes a tick every clock cycle while not stalled: all state
// (mode, button, clap timing, color wheel) is updated in the cycle the tick
// is accepted, and the result is written to an output register on that same edge. The input is stalled
// only while a finished result sits in that register and the sink stalls it.
// Configuration writes are meant for idle periods and take effect at once.
// ----------------------------------------------------------------------------
module sound_reactive_rgb_light_controller #(
    parameter int SAMPLE_BITS = 10,
    parameter int WHEEL_TOP   = 900,
    parameter int BAND_WIDTH  = 100
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [15:0]            i_cfg_data,

    // sample tick channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_mic_sample,
    input  logic                   i_button_level,
    input  logic [31:0]            i_now_ms,

    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_red_duty,
    output logic [7:0]             o_green_duty,
    output logic [7:0]             o_blue_duty,
    output logic [2:0]             o_current_mode,
    output logic [1:0]             o_claps_counted
);

    // width that holds both the sample and the 10-bit center
    localparam int DW = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;

    // configuration registers
    logic [9:0]  r_quiet_center;
    logic [9:0]  r_quiet_deadband;
    logic [15:0] r_clap_hold_ms;
    logic [15:0] r_clap_gap_ms;

    // controller state
    logic [2:0]  r_mode,        n_mode;
    logic        r_btn_held,    n_btn_held;
    logic [1:0]  r_clap_cnt,    n_clap_cnt;
    logic        r_clap_armed,  n_clap_armed;
    logic [31:0] r_clap_start,  n_clap_start;
    logic [31:0] r_gap_start,   n_gap_start;
    logic [9:0]  r_wheel_cnt,   n_wheel_cnt;
    logic        r_wheel_up,    n_wheel_up;
    srrlc_pkg::t_rgb r_level,   n_level;

    // result register
    logic        r_out_valid;
    srrlc_pkg::t_rgb r_out_rgb;
    logic [2:0]  r_out_mode;
    logic [1:0]  r_out_claps;

    logic        in_accept;
    logic [DW-1:0] sample_x;
    logic [DW-1:0] center_x;
    logic [DW-1:0] dev;
    logic        sound;
    logic [31:0] since_clap;
    logic [31:0] since_gap;
    logic [3:0]  band;

    // result slot frees up when empty or being taken this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // sound detect: |center - sample| > deadband
    assign sample_x = DW'(i_mic_sample);
    assign center_x = DW'(r_quiet_center);
    assign dev      = (sample_x > center_x) ? (sample_x - center_x) : (center_x - sample_x);
    assign sound    = dev > DW'(r_quiet_deadband);

    // modular elapsed time for clap hold and gap
    assign since_clap = i_now_ms - r_clap_start;
    assign since_gap  = i_now_ms - r_gap_start;

    always_comb begin
        n_mode       = r_mode;
        n_btn_held   = r_btn_held;
        n_clap_cnt   = r_clap_cnt;
        n_clap_armed = r_clap_armed;
        n_clap_start = r_clap_start;
        n_gap_start  = r_gap_start;
        n_wheel_cnt  = r_wheel_cnt;
        n_wheel_up   = r_wheel_up;
        n_level      = r_level;
        band         = '0;

        // button release steps the mode, effective on this tick
        if (i_button_level) begin
            n_btn_held = 1'b1;
        end else if (r_btn_held) begin
            n_btn_held = 1'b0;
            n_mode = (r_mode >= srrlc_pkg::MODE_WHEEL) ? srrlc_pkg::MODE_CLAP : r_mode + 3'd1;
        end

        case (n_mode)
            srrlc_pkg::MODE_CLAP: begin
                if (sound) begin
                    if (!r_clap_armed) begin
                        // start of a new clap
                        n_clap_armed = 1'b1;
                        n_clap_start = i_now_ms;
                        n_gap_start  = i_now_ms;
                        if (r_clap_cnt != 2'd3) begin
                            n_clap_cnt = r_clap_cnt + 2'd1;
                        end
                    end else if (since_clap > 32'(r_clap_hold_ms)) begin
                        // clap lasted long enough, rearm
                        n_clap_armed = 1'b0;
                    end
                end else if (r_clap_cnt != 2'd0 && since_gap > 32'(r_clap_gap_ms)) begin
                    n_clap_cnt = 2'd0;
                end
                if (n_clap_cnt == 2'd1) begin
                    n_level = '{srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF};
                end else if (n_clap_cnt == 2'd2) begin
                    n_level = '{srrlc_pkg::LVL_FULL, srrlc_pkg::LVL_FULL,
                                srrlc_pkg::LVL_FULL};
                end
            end
            srrlc_pkg::MODE_BLUE: begin
                n_level = '{srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF,
                            sound ? srrlc_pkg::LVL_FULL : srrlc_pkg::LVL_OFF};
            end
            srrlc_pkg::MODE_GREEN: begin
                n_level = '{srrlc_pkg::LVL_OFF,
                            sound ? srrlc_pkg::LVL_FULL : srrlc_pkg::LVL_OFF,
                            srrlc_pkg::LVL_OFF};
            end
            srrlc_pkg::MODE_RED: begin
                n_level = '{sound ? srrlc_pkg::LVL_FULL : srrlc_pkg::LVL_OFF,
                            srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF};
            end
            srrlc_pkg::MODE_WHITE: begin
                n_level = sound ? '{srrlc_pkg::LVL_FULL, srrlc_pkg::LVL_FULL,
                                    srrlc_pkg::LVL_FULL}
                                : '{srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF,
                                    srrlc_pkg::LVL_OFF};
            end
            default: begin
                // color wheel: bouncing counter while there is sound
                if (!sound) begin
                    n_level = '{srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF};
                end else begin
                    if (r_wheel_up) begin
                        if (r_wheel_cnt < 10'(WHEEL_TOP)) begin
                            n_wheel_cnt = r_wheel_cnt + 10'd1;
                        end
                        if (n_wheel_cnt >= 10'(WHEEL_TOP)) begin
                            n_wheel_up = 1'b0;
                        end
                    end else begin
                        if (r_wheel_cnt != 10'd0) begin
                            n_wheel_cnt = r_wheel_cnt - 10'd1;
                        end
                        if (n_wheel_cnt == 10'd0) begin
                            n_wheel_up = 1'b1;
                        end
                    end
                    // band = (count-1)/width, found by counting passed thresholds
                    for (int k = 1; k < srrlc_pkg::NUM_BANDS; k++) begin
                        if (11'(n_wheel_cnt) > 11'(k * BAND_WIDTH)) begin
                            band = band + 4'd1;
                        end
                    end
                    n_level = srrlc_pkg::band_color(band);
                end
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_center   <= 10'd503;
            r_quiet_deadband <= 10'd10;
            r_clap_hold_ms   <= 16'd150;
            r_clap_gap_ms    <= 16'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srrlc_pkg::CFG_QUIET_CENTER:   r_quiet_center   <= i_cfg_data[9:0];
                srrlc_pkg::CFG_QUIET_DEADBAND: r_quiet_deadband <= i_cfg_data[9:0];
                srrlc_pkg::CFG_CLAP_HOLD_MS:   r_clap_hold_ms   <= i_cfg_data;
                srrlc_pkg::CFG_CLAP_GAP_MS:    r_clap_gap_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // controller state, advances once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= srrlc_pkg::MODE_CLAP;
            r_btn_held   <= 1'b0;
            r_clap_cnt   <= 2'd0;
            r_clap_armed <= 1'b0;
            r_clap_start <= 32'd0;
            r_gap_start  <= 32'd0;
            r_wheel_cnt  <= 10'd0;
            r_wheel_up   <= 1'b1;
            r_level      <= '0;
        end else if (in_accept) begin
            r_mode       <= n_mode;
            r_btn_held   <= n_btn_held;
            r_clap_cnt   <= n_clap_cnt;
            r_clap_armed <= n_clap_armed;
            r_clap_start <= n_clap_start;
            r_gap_start  <= n_gap_start;
            r_wheel_cnt  <= n_wheel_cnt;
            r_wheel_up   <= n_wheel_up;
            r_level      <= n_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_rgb   <= n_level;
            r_out_mode  <= n_mode;
            r_out_claps <= n_clap_cnt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_red_duty      = r_out_rgb.red;
    assign o_green_duty    = r_out_rgb.green;
    assign o_blue_duty     = r_out_rgb.blue;
    assign o_current_mode  = r_out_mode;
    assign o_claps_counted = r_out_claps;

endmodule

@@ tb/sv/light_duty_check_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_duty_check_pkg
// duty level prediction and result checking for the sound reactive light
// controller testbench
// ----------------------------------------------------------------------------
package light_duty_check_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int WHEEL_TOP  = 900;
    localparam int BAND_WIDTH = 100;

    // red, green, blue of each wheel band
    localparam logic [23:0] WHEEL_RGB [0:8] = '{
        24'hFF0000, 24'hAA5500, 24'h55AA00,
        24'h00FF00, 24'h00AA55, 24'h0055AA,
        24'h0000FF, 24'h5500AA, 24'hAA0055
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] mode;
        logic [1:0] claps;
    } t_duty_beat;

    class light_duty_scoreboard;
        logic [9:0]  center;
        logic [9:0]  deadband;
        logic [15:0] hold_ms;
        logic [15:0] gap_ms;

        logic [2:0]  mode;
        logic        held;
        logic [1:0]  claps;
        logic        armed;
        logic [31:0] clap_t0;
        logic [31:0] gap_t0;
        logic [9:0]  wheel;
        logic        wheel_up;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;

        t_duty_beat  duty_expected[$];
        int unsigned n_checked;
        int unsigned n_errors;

        function new();
            center    = 10'd503;
            deadband  = 10'd10;
            hold_ms   = 16'd150;
            gap_ms    = 16'd500;
            mode      = srrlc_pkg::MODE_CLAP;
            held      = 1'b0;
            claps     = 2'd0;
            armed     = 1'b0;
            clap_t0   = '0;
            gap_t0    = '0;
            wheel     = '0;
            wheel_up  = 1'b1;
            red       = srrlc_pkg::LVL_OFF;
            green     = srrlc_pkg::LVL_OFF;
            blue      = srrlc_pkg::LVL_OFF;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                srrlc_pkg::CFG_QUIET_CENTER:   center   = data[9:0];
                srrlc_pkg::CFG_QUIET_DEADBAND: deadband = data[9:0];
                srrlc_pkg::CFG_CLAP_HOLD_MS:   hold_ms  = data;
                srrlc_pkg::CFG_CLAP_GAP_MS:    gap_ms   = data;
                default: ;
            endcase
        endfunction

        // advance the light state by one tick and queue the duty beat it gives
        function void note_tick(logic [SAMPLE_W-1:0] sample, logic button, logic [31:0] now);
            logic [9:0]  dev;
            logic        sound;
            logic [31:0] elapsed;
            int          band;
            logic [7:0]  lvl;
            t_duty_beat  want;

            dev   = (sample > center) ? sample - center : center - sample;
            sound = dev > deadband;
            lvl   = sound ? srrlc_pkg::LVL_FULL : srrlc_pkg::LVL_OFF;

            if (button) begin
                held = 1'b1;
            end else if (held) begin
                held = 1'b0;
                mode = (mode >= srrlc_pkg::MODE_WHEEL) ? srrlc_pkg::MODE_CLAP : mode + 3'd1;
            end

            case (mode)
                srrlc_pkg::MODE_CLAP: begin
                    if (sound) begin
                        elapsed = now - clap_t0;
                        if (!armed) begin
                            armed   = 1'b1;
                            clap_t0 = now;
                            gap_t0  = now;
                            if (claps != 2'd3)
                                claps = claps + 2'd1;
                        end else if (elapsed > {16'd0, hold_ms}) begin
                            armed = 1'b0;
                        end
                    end else begin
                        elapsed = now - gap_t0;
                        if (claps != 2'd0 && elapsed > {16'd0, gap_ms})
                            claps = 2'd0;
                    end
                    if (claps == 2'd1)
                        {red, green, blue} = {3{srrlc_pkg::LVL_OFF}};
                    else if (claps == 2'd2)
                        {red, green, blue} = {3{srrlc_pkg::LVL_FULL}};
                end
                srrlc_pkg::MODE_BLUE:
                    {red, green, blue} = {srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF, lvl};
                srrlc_pkg::MODE_GREEN:
                    {red, green, blue} = {srrlc_pkg::LVL_OFF, lvl, srrlc_pkg::LVL_OFF};
                srrlc_pkg::MODE_RED:
                    {red, green, blue} = {lvl, srrlc_pkg::LVL_OFF, srrlc_pkg::LVL_OFF};
                srrlc_pkg::MODE_WHITE:
                    {red, green, blue} = {3{lvl}};
                default: begin
                    if (!sound) begin
                        {red, green, blue} = {3{srrlc_pkg::LVL_OFF}};
                    end else begin
                        if (wheel_up) begin
                            if (wheel < WHEEL_TOP)
                                wheel = wheel + 10'd1;
                            if (wheel >= WHEEL_TOP)
                                wheel_up = 1'b0;
                        end else begin
                            if (wheel > 0)
                                wheel = wheel - 10'd1;
                            if (wheel == 0)
                                wheel_up = 1'b1;
                        end
                        band = (wheel == 0) ? 0 : (int'(wheel) - 1) / BAND_WIDTH;
                        if (band >= srrlc_pkg::NUM_BANDS)
                            band = srrlc_pkg::NUM_BANDS - 1;
                        {red, green, blue} = WHEEL_RGB[band];
                    end
                end
            endcase

            want = '{red, green, blue, mode, claps};
            duty_expected.push_back(want);
        endfunction

        function void check_beat(logic [7:0] r_duty, logic [7:0] g_duty, logic [7:0] b_duty,
                                 logic [2:0] mode_seen, logic [1:0] claps_seen);
            t_duty_beat got;
            t_duty_beat want;

            got = '{r_duty, g_duty, b_duty, mode_seen, claps_seen};
            n_checked++;
            if (duty_expected.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t duty beat %0d with nothing pending: %s %0d/%0d/%0d %s %0d %s %0d",
                             $time, n_checked, "rgb", r_duty, g_duty, b_duty,
                             "mode", mode_seen, "claps", claps_seen);
                return;
            end
            want = duty_expected.pop_front();
            if (got !== want) begin
                n_errors++;
                if (n_errors <= 10)
                    $display({"%0t duty beat %0d differs: want rgb %0d/%0d/%0d mode %0d",
                              " claps %0d, got rgb %0d/%0d/%0d mode %0d claps %0d"},
                             $time, n_checked, want.red, want.green, want.blue, want.mode,
                             want.claps, r_duty, g_duty, b_duty, mode_seen, claps_seen);
            end
        endfunction

        function int pending();
            return duty_expected.size();
        endfunction
    endclass

endpackage

@@ tb/sv/sound_reactive_rgb_light_controller_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sound_reactive_rgb_light_controller_tb
// self-checking bench for the sound reactive rgb light controller
// ----------------------------------------------------------------------------
// Sample ticks go in through the valid/stall channel; every accepted tick is
// run through a scoreboard that keeps its own copy of the mode, clap timing
// and color wheel state and queues the duty beat it should produce. Every
// result beat is checked against the oldest queued one. A short directed
// run covers clap counting, timeouts across the timestamp wrap and every
// mode, then random runs with loud/quiet bursts and button presses go over
// several register settings and idle patterns, ending in a long color wheel
// sweep that runs the counter into at least one of its turning points.
// ----------------------------------------------------------------------------
module sound_reactive_rgb_light_controller_tb;

    logic                                      i_clk = 1'b0;
    logic                                      i_rst_n;
    logic                                      i_cfg_we;
    logic [1:0]                                i_cfg_idx;
    logic [15:0]                               i_cfg_data;
    logic                                      i_in_valid;
    logic                                      o_in_stall;
    logic [light_duty_check_pkg::SAMPLE_W-1:0] i_mic_sample;
    logic                                      i_button_level;
    logic [31:0]                               i_now_ms;
    logic                                      o_out_valid;
    logic                                      i_out_stall;
    logic [7:0]                                o_red_duty;
    logic [7:0]                                o_green_duty;
    logic [7:0]                                o_blue_duty;
    logic [2:0]                                o_current_mode;
    logic [1:0]                                o_claps_counted;

    light_duty_check_pkg::light_duty_scoreboard duty_board;

    // idle odds in percent for the tick source and the result sink
    int in_idle_pct  = 17;
    int out_idle_pct = 55;
    // asks the sink process for one long hold-off
    logic stall_burst_req = 1'b0;

    // register values the sample picker aims around
    logic [9:0]  cfg_center   = 10'd503;
    logic [9:0]  cfg_deadband = 10'd10;

    // tick generator state
    logic [31:0] tick_ms;
    logic        loud_run;
    int          run_left;
    int          press_left;
    // mode as seen from the button presses already sent
    logic [2:0]  drv_mode;
    logic        drv_held;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sound_reactive_rgb_light_controller #(
        .SAMPLE_BITS (light_duty_check_pkg::SAMPLE_W),
        .WHEEL_TOP   (light_duty_check_pkg::WHEEL_TOP),
        .BAND_WIDTH  (light_duty_check_pkg::BAND_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mic_sample    (i_mic_sample),
        .i_button_level  (i_button_level),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_red_duty      (o_red_duty),
        .o_green_duty    (o_green_duty),
        .o_blue_duty     (o_blue_duty),
        .o_current_mode  (o_current_mode),
        .o_claps_counted (o_claps_counted)
    );

    // beat monitor: everything here sees the values from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                duty_board.write_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                duty_board.note_tick(i_mic_sample, i_button_level, i_now_ms);
            if (o_out_valid && !i_out_stall)
                duty_board.check_beat(o_red_duty, o_green_duty, o_blue_duty,
                                      o_current_mode, o_claps_counted);
        end
    end

    // result sink: random stalls, plus one long hold-off on request
    initial begin
        int burst_left;
        burst_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                burst_left = 250;
            end
            if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    // hard stop for a hung run
    initial begin
        #2_000_000;
        $display("sound_reactive_rgb_light_controller: mismatch");
        $finish;
    end

    // offer one tick and hold it until the block takes it
    task automatic send_tick(input logic [light_duty_check_pkg::SAMPLE_W-1:0] sample,
                             input logic button, input logic [31:0] now);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mic_sample   <= sample;
        i_button_level <= button;
        i_now_ms       <= now;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        // track the mode the release steps to
        if (button) begin
            drv_held = 1'b1;
        end else if (drv_held) begin
            drv_held = 1'b0;
            drv_mode = (drv_mode >= srrlc_pkg::MODE_WHEEL) ? srrlc_pkg::MODE_CLAP
                                                           : drv_mode + 3'd1;
        end
    endtask

    // write all four registers back to back, block idle
    task automatic apply_settings(input logic [9:0] center, input logic [9:0] deadband,
                                  input logic [15:0] hold, input logic [15:0] gap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= srrlc_pkg::CFG_QUIET_CENTER;
        i_cfg_data <= {6'd0, center};
        @(posedge i_clk);
        i_cfg_idx  <= srrlc_pkg::CFG_QUIET_DEADBAND;
        i_cfg_data <= {6'd0, deadband};
        @(posedge i_clk);
        i_cfg_idx  <= srrlc_pkg::CFG_CLAP_HOLD_MS;
        i_cfg_data <= hold;
        @(posedge i_clk);
        i_cfg_idx  <= srrlc_pkg::CFG_CLAP_GAP_MS;
        i_cfg_data <= gap;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cfg_center   = center;
        cfg_deadband = deadband;
    endtask

    // stop offering and wait for every queued duty beat to come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (duty_board.pending() != 0)
            @(posedge i_clk);
    endtask

    // sample just outside (loud) or inside (quiet) the deadband, often at its edge
    function automatic logic [light_duty_check_pkg::SAMPLE_W-1:0] pick_sample(input bit loud);
        int lo_q;
        int hi_q;
        int v;
        lo_q = int'(cfg_center) - int'(cfg_deadband);
        hi_q = int'(cfg_center) + int'(cfg_deadband);
        if (loud && lo_q > 0 && (hi_q >= 1023 || $urandom_range(0, 1) == 0)) begin
            v = ($urandom_range(0, 3) == 0) ? lo_q - 1 : $urandom_range(0, lo_q - 1);
        end else if (loud && hi_q < 1023) begin
            v = ($urandom_range(0, 3) == 0) ? hi_q + 1 : $urandom_range(hi_q + 1, 1023);
        end else begin
            // quiet, or no loud value exists at this deadband
            if (lo_q < 0)
                lo_q = 0;
            if (hi_q > 1023)
                hi_q = 1023;
            if ($urandom_range(0, 3) == 0)
                v = $urandom_range(0, 1) ? lo_q : hi_q;
            else
                v = $urandom_range(lo_q, hi_q);
        end
        return v[light_duty_check_pkg::SAMPLE_W-1:0];
    endfunction

    // loud bursts of clap length, quiet stretches past the gap time,
    // occasional button presses and a share of plain noise
    task automatic random_ticks(input int count);
        logic [light_duty_check_pkg::SAMPLE_W-1:0] sample;
        logic                                      button;
        int                                        r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                tick_ms += $urandom_range(0, 70000);
            else if (r < 6)
                tick_ms = $urandom();
            else
                tick_ms += $urandom_range(0, 30);

            if (run_left == 0) begin
                loud_run = !loud_run;
                run_left = loud_run ? $urandom_range(1, 14) : $urandom_range(1, 60);
            end
            run_left--;
            sample = pick_sample(loud_run);

            if (press_left > 0) begin
                button = 1'b1;
                press_left--;
            end else if ($urandom_range(0, 39) == 0) begin
                button = 1'b1;
                press_left = $urandom_range(0, 3);
            end else begin
                button = 1'b0;
            end

            if ($urandom_range(0, 99) < 8) begin
                sample = light_duty_check_pkg::SAMPLE_W'($urandom_range(0, 1023));
                button = 1'($urandom_range(0, 1));
            end
            send_tick(sample, button, tick_ms);
        end
    endtask

    // step into the color wheel and keep it loud long enough to reach a turning point
    task automatic wheel_sweep(input int count);
        while (drv_mode != srrlc_pkg::MODE_WHEEL) begin
            tick_ms += 5;
            send_tick(pick_sample(1'b0), 1'b1, tick_ms);
            send_tick(pick_sample(1'b0), 1'b0, tick_ms);
        end
        repeat (count) begin
            tick_ms += $urandom_range(0, 30);
            send_tick(pick_sample($urandom_range(0, 99) != 0), 1'b0, tick_ms);
        end
    endtask

    initial begin
        duty_board = new();

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= srrlc_pkg::CFG_QUIET_CENTER;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_mic_sample   <= '0;
        i_button_level <= 1'b0;
        i_now_ms       <= '0;
        tick_ms    = 32'h0000_0700;
        loud_run   = 1'b0;
        run_left   = 0;
        press_left = 0;
        drv_mode   = srrlc_pkg::MODE_CLAP;
        drv_held   = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, reset register values: center 503, deadband 10 ----
        // clap sequence straddling the timestamp wrap
        send_tick(10'd503,  1'b0, 32'hFFFF_FF00);  // silence right at center
        send_tick(10'd0,    1'b0, 32'hFFFF_FF10);  // first clap, light off
        send_tick(10'd1023, 1'b0, 32'h0000_00D8);  // held past hold time over the wrap, rearm
        send_tick(10'd1023, 1'b0, 32'h0000_00E0);  // second clap, full white
        send_tick(10'd0,    1'b0, 32'h0000_0176);  // exactly the hold time, still armed
        send_tick(10'd0,    1'b0, 32'h0000_0177);  // one past hold, rearm
        send_tick(10'd514,  1'b0, 32'h0000_0180);  // one above deadband, third clap
        send_tick(10'd492,  1'b0, 32'h0000_0300);  // sound while armed only rearms
        send_tick(10'd492,  1'b0, 32'h0000_0301);  // fourth clap, count stays at three
        send_tick(10'd513,  1'b0, 32'h0000_04F5);  // deadband edge is quiet, gap not yet over
        send_tick(10'd493,  1'b0, 32'h0000_04F6);  // one past gap, count cleared, white holds
        send_tick(10'd0,    1'b0, 32'h0000_0500);  // still armed from before, no clap counted
        // press and release through every mode and back around to clap
        for (int m = 1; m <= 6; m++) begin
            send_tick(10'd1023, 1'b1, 32'hFFFF_FFFF);
            send_tick(m[0] ? 10'd0 : 10'd503, 1'b0, 32'h0000_0600 + m);
        end
        drain_results();

        // ---- source idles lightly, sink idles a lot ----
        apply_settings(10'd503, 10'd10, 16'd150, 16'd500);
        random_ticks(50);
        drain_results();
        // lowest settings: any nonzero offset is sound, both timeouts at zero
        apply_settings(10'd0, 10'd0, 16'd0, 16'd0);
        random_ticks(30);
        drain_results();

        // ---- source idles a lot, sink idles lightly ----
        in_idle_pct  = 55;
        out_idle_pct = 17;
        apply_settings(10'd1023, 10'd100, 16'hFFFF, 16'hFFFF);
        random_ticks(30);
        drain_results();
        // widest deadband, nothing ever counts as sound
        apply_settings(10'd512, 10'd1023, 16'd40, 16'd80);
        random_ticks(15);
        drain_results();
        apply_settings(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 60)),
                       16'($urandom_range(0, 300)), 16'($urandom_range(0, 1000)));
        random_ticks(40);
        drain_results();

        // ---- no idling; long sink hold-off lets the block fill and stall ----
        in_idle_pct  = 0;
        out_idle_pct = 0;
        apply_settings(10'd300, 10'd5, 16'd20, 16'd60);
        stall_burst_req = 1'b1;
        random_ticks(60);
        drain_results();
        apply_settings(10'($urandom_range(100, 900)), 10'($urandom_range(0, 40)),
                       16'($urandom_range(0, 400)), 16'($urandom_range(0, 1500)));
        random_ticks(25);
        wheel_sweep(960);
        drain_results();

        repeat (8) @(posedge i_clk);
        if (duty_board.n_errors == 0 && duty_board.pending() == 0)
            $display("sound_reactive_rgb_light_controller: match");
        else
            $display("sound_reactive_rgb_light_controller: mismatch");
        $finish;
    end

endmodule
